/* rtl/assert_macros.svh */
// assertion macros for the rtl files, included by the controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) expr) else $error("assert failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("never failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, expr)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* rtl/pba_pkg.sv */
// shared types and constants of the page bitmap allocator
package pba_pkg;
  localparam int NUM_PAGES = 4096;
  localparam int WORD_BITS = 32;
  localparam int NUM_WORDS = NUM_PAGES / WORD_BITS;
  localparam int WADDR_W   = 7;
  localparam int WCNT_W    = 8;
  localparam int PAGE_W    = 12;
  localparam int COUNT_W   = 13;

  typedef enum logic [1:0] {
    MODE_ALLOC     = 2'd0,
    MODE_FREE      = 2'd1,
    MODE_MARK_USED = 2'd2,
    MODE_MARK_FREE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture request, reset scan
    logic rd;        // issue word read at addr
    logic scan;      // evaluate one 8-bit slice of the read word for alloc
    logic wr;        // write back modified word
    logic adv_word;  // advance word address
    logic set_bits;  // write value is set (else clear)
  } pba_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic found;      // alloc run complete in current slice
    logic last_chunk; // current slice is the last one to scan in this word
    logic last_word;  // current word is last in use
    logic no_words;   // zero words in use
    logic run_done;   // set/clear run finished
    logic bad_page;   // mark or free rejected
    logic count_zero;
  } pba_stat_t;
endpackage

/* rtl/pba_if.sv */
// valid/ready channel interface
interface pba_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/pba_ctrl.sv */
// controller state machine of the page bitmap allocator
`include "assert_macros.svh"
module pba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  output logic                out_valid,
  input  logic                out_ready,
  output pba_pkg::status_t    status,
  output pba_pkg::pba_cmd_t   cmd,
  output logic                res_alloc,
  input  pba_pkg::pba_stat_t  st
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_SRD   = 7'b0000100,
    S_SEVAL = 7'b0001000,
    S_WRD   = 7'b0010000,
    S_WWR   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  pba_pkg::status_t status_r, status_nxt;
  logic alloc_r, alloc_nxt, set_r, set_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign status    = status_r;
  assign res_alloc = alloc_r;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    alloc_nxt  = alloc_r;
    set_nxt    = set_r;
    cmd        = '0;
    cmd.set_bits = set_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          alloc_nxt = (mode == pba_pkg::MODE_ALLOC);
          set_nxt   = (mode == pba_pkg::MODE_ALLOC) || (mode == pba_pkg::MODE_MARK_USED);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        status_nxt = pba_pkg::ST_DONE;
        if (alloc_r) begin
          if (st.count_zero) begin
            status_nxt = pba_pkg::ST_IGNORED;
            state_nxt  = S_OUT;
          end else if (st.no_words) begin
            status_nxt = pba_pkg::ST_NOFIT;
            state_nxt  = S_OUT;
          end else begin
            cmd.rd    = 1'b1;
            state_nxt = S_SRD;
          end
        end else if (st.bad_page) begin
          status_nxt = pba_pkg::ST_IGNORED;
          state_nxt  = S_OUT;
        end else if (st.run_done) begin
          state_nxt = S_OUT;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_WRD;
        end
      end
      S_SRD: state_nxt = S_SEVAL;
      // one slice per cycle until a hit or the end of the word
      S_SEVAL: begin
        cmd.scan = 1'b1;
        if (st.found) begin
          state_nxt = S_CHECK;
          alloc_nxt = 1'b0;
        end else if (st.last_chunk) begin
          if (st.last_word) begin
            status_nxt = pba_pkg::ST_NOFIT;
            state_nxt  = S_OUT;
          end else begin
            cmd.adv_word = 1'b1;
            cmd.rd       = 1'b1;
            state_nxt    = S_SRD;
          end
        end
      end
      S_WRD: state_nxt = S_WWR;
      S_WWR: begin
        cmd.wr    = 1'b1;
        state_nxt = S_CHECK;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= pba_pkg::ST_DONE;
      alloc_r  <= 1'b0;
      set_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      alloc_r  <= alloc_nxt;
      set_r    <= set_nxt;
    end
  end

  `ASSERT_IMPL(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid)
  `ASSERT_NEVER(a_no_ready_busy, clk, rst_n, in_ready && out_valid)
  `ASSERT_IMPL(a_wr_after_rd, clk, rst_n, cmd.wr |-> $past(state_r == S_WRD))
endmodule

/* rtl/pba_dp.sv */
// datapath of the page bitmap allocator: bitmap memory, scan and run update
module pba_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [pba_pkg::COUNT_W-1:0]     page_count,
  input  logic [pba_pkg::PAGE_W-1:0]      in_page,
  input  logic [pba_pkg::COUNT_W-1:0]     in_count,
  input  logic [1:0]                      in_mode,
  input  pba_pkg::pba_cmd_t               cmd,
  input  logic                            res_alloc,
  output pba_pkg::pba_stat_t              st,
  output logic [pba_pkg::PAGE_W-1:0]      start_page
);
  localparam int NW = pba_pkg::NUM_WORDS;
  localparam int AW = pba_pkg::WADDR_W;
  localparam int PW = pba_pkg::PAGE_W;
  localparam int CW = pba_pkg::COUNT_W;
  localparam int WB = pba_pkg::WORD_BITS;
  localparam int WW = pba_pkg::WCNT_W;

  logic [WB-1:0] mem [NW];
  logic [WB-1:0] rdata_r;
  logic [NW-1:0] wvalid_r;
  logic          rvalid_r;
  logic [AW-1:0] rd_addr_r;
  logic [AW-1:0] rd_addr;
  logic [PW-1:0] pos_r, pos_nxt;        // current page of run walk
  logic [CW-1:0] rem_r, rem_nxt;        // pages left to set/clear
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] run_r, run_nxt;
  logic [PW-1:0] first_r, first_nxt;
  logic [AW-1:0] widx_r, widx_nxt;
  logic [1:0]    chunk_r, chunk_nxt;    // 8-bit slice of the word under scan
  logic          mark_r;
  logic          bad_r;
  logic [PW-1:0] start_r;
  logic [WW-1:0] words;
  logic [WB-1:0] word;
  logic [WB-1:0] wmask;
  logic          found;
  logic [CW-1:0] pc_words;
  logic [5:0]    span;
  logic [PW:0]   pos_ext;

  // words in use, saturated
  assign pc_words = page_count >> 5;
  assign words = (pc_words > CW'(NW)) ? WW'(NW) : WW'(pc_words);
  assign word  = rvalid_r ? rdata_r : '1;

  // bit scan over one 8-bit slice of the read word
  always_comb begin
    logic [CW-1:0] r;
    logic [PW-1:0] f;
    logic          hit;
    logic [7:0]    part;
    r = run_r; f = first_r; hit = 1'b0;
    part = word[{chunk_r, 3'b000} +: 8];
    if (word == '1) begin
      r = '0;
    end else begin
      for (int k = 0; k < 8; k++) begin
        if (!hit) begin
          if (!part[k]) begin
            if (r == '0) f = {widx_r, chunk_r, 3'(k)};
            r = r + 1'b1;
            if (r == cnt_r) hit = 1'b1;
          end else begin
            r = '0;
          end
        end
      end
    end
    run_nxt = r; first_nxt = f; found = hit;
  end

  // mask of bits in current word touched by the run
  always_comb begin
    wmask = '0;
    for (int b = 0; b < WB; b++) begin
      if (5'(b) >= pos_r[4:0] && (CW'(b) - CW'(pos_r[4:0])) < rem_r) wmask[b] = 1'b1;
    end
  end

  // pages from pos_r to the end of its word, and the next word start
  assign span    = 6'd32 - {1'b0, pos_r[4:0]};
  assign pos_ext = {1'b0, pos_r} + {7'd0, span};

  // status to controller
  always_comb begin
    st = '0;
    st.found      = found;
    st.last_chunk = (chunk_r == 2'd3) || (word == '1);
    st.last_word  = ((WW'(widx_r) + 1'b1) >= words);
    st.no_words   = (words == '0);
    st.count_zero = (cnt_r == '0);
    st.run_done   = (rem_r == '0) || (!mark_r && (WW'(pos_r[PW-1:5]) >= words));
    st.bad_page   = bad_r;
  end

  // request capture and run walk
  always_comb begin
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;
    widx_nxt  = widx_r;
    chunk_nxt = chunk_r;
    if (cmd.load) begin
      pos_nxt   = in_page;
      rem_nxt   = in_mode[1] ? 13'd1 : in_count;
      widx_nxt  = '0;
      chunk_nxt = '0;
    end else if (cmd.scan && found) begin
      pos_nxt = first_nxt;
      rem_nxt = cnt_r;
    end else begin
      if (cmd.rd) chunk_nxt = '0;
      else if (cmd.scan) chunk_nxt = chunk_r + 1'b1;
      if (cmd.adv_word) widx_nxt = widx_r + 1'b1;
      if (cmd.wr) begin
        if (pos_ext[PW] || (CW'(span) >= rem_r)) rem_nxt = '0;
        else rem_nxt = rem_r - CW'(span);
        pos_nxt = pos_ext[PW-1:0];
      end
    end
  end

  assign rd_addr = cmd.adv_word ? widx_r + 1'b1 : (res_alloc ? widx_r : pos_r[PW-1:5]);

  // bitmap memory
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_addr_r <= rd_addr;
      rdata_r   <= mem[rd_addr];
    end
    if (cmd.wr) mem[rd_addr_r] <= cmd.set_bits ? (word | wmask) : (word & ~wmask);
  end

  // valid bits and result start page
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvalid_r <= '0;
      rvalid_r <= 1'b0;
      start_r  <= '0;
    end else begin
      if (cmd.rd) rvalid_r <= wvalid_r[rd_addr];
      if (cmd.wr) wvalid_r[rd_addr_r] <= 1'b1;
      if (cmd.load) start_r <= '0;
      else if (cmd.scan && found) start_r <= first_nxt;
    end
  end

  // walk, scan and request registers
  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    rem_r   <= rem_nxt;
    widx_r  <= widx_nxt;
    chunk_r <= chunk_nxt;
    if (cmd.load) begin
      cnt_r   <= in_count; run_r <= '0; first_r <= '0;
      mark_r  <= in_mode[1];
      bad_r   <= ((in_mode == pba_pkg::MODE_FREE) && (in_page == '0)) ||
                 (in_mode[1] && ({1'b0, in_page} >= page_count));
    end else if (cmd.scan) begin
      run_r <= run_nxt; first_r <= first_nxt;
    end
  end

  assign start_page = start_r;
endmodule

/* rtl/page_bitmap_allocator_core.sv */
// top level of the page bitmap allocator
// Usage: requests arrive on in_ch (mode, page_index, count), results leave on
// out_ch (status, start_page), one result per request. cfg_we/cfg_wdata set
// page_count while no request is in flight.
// Flow: a rejected request, a free that touches no word, or an allocate
// with zero count or no words in use goes from S_CHECK straight to S_OUT.
// A mark or a free reads and writes back each bitmap word that it touches
// (S_WRD, S_WWR). An allocate scans word by word (S_SRD read, then S_SEVAL
// one 8-bit slice per cycle; an all-used word ends after its first slice),
// then marks the run it found word by word in the same way.
// The bitmap memory gives one registered word read and one write per touched
// word.
// One request at a time: in_ch.ready is high only when idle, so the next
// request can be taken in the cycle after the result is taken.
// Reset: all pages read as used through per-word valid bits, page_count is 0.
// A stalled result stays on out_ch until taken; no new request is taken.
module page_bitmap_allocator_core (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cfg_we,
  input  logic [12:0] cfg_wdata,
  pba_if.sink   in_ch,
  pba_if.source out_ch
);
  logic [12:0] page_count_r;
  pba_pkg::pba_cmd_t  cmd;
  pba_pkg::pba_stat_t st;
  pba_pkg::status_t   status;
  logic res_alloc;
  logic [11:0] start_page;
  logic [1:0]  in_mode;
  logic [11:0] in_page_index;
  logic [12:0] in_count;

  assign {in_mode, in_page_index, in_count} = in_ch.data;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) page_count_r <= '0;
    else if (cfg_we) page_count_r <= cfg_wdata;
  end

  pba_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .mode(in_mode),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status, .cmd, .res_alloc, .st
  );

  pba_dp u_dp (
    .clk, .rst_n, .page_count(page_count_r),
    .in_page(in_page_index), .in_count, .in_mode,
    .cmd, .res_alloc, .st, .start_page(start_page)
  );

  assign out_ch.data = {status, (status == pba_pkg::ST_DONE) ? start_page : 12'd0};
endmodule

/* tb/tb.sv */
// testbench of the page bitmap allocator core: directed table, then random traffic
`timescale 1ns / 100ps

module tb;
  localparam int NWORDS = pba_pkg::NUM_WORDS;

  typedef struct {
    bit                is_cfg;
    pba_pkg::mode_t    mode;
    int                page;
    int                count;
    bit                typed;
    pba_pkg::status_t  st;
    int                sp;
  } row_t;

  typedef struct {
    pba_pkg::status_t st;
    logic [11:0]      sp;
  } outcome_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [12:0] cfg_wdata;

  pba_if #(27) in_ch ();
  pba_if #(14) out_ch ();

  page_bitmap_allocator_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // shadow copy of the bitmap and of page_count
  logic [31:0] used_map [NWORDS];
  int          managed_pages;
  outcome_t    pending_q[$];
  int          errors;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cycles;
  row_t        rows[$];
  int          phase_pages[7];

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // overall time limit
  initial begin
    #200ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic int words_used();
    int w;
    w = managed_pages / 32;
    if (w > NWORDS) w = NWORDS;
    return w;
  endfunction

  function automatic void put_bit(int pg, bit used);
    if (pg / 32 >= NWORDS) return;
    used_map[pg / 32][pg % 32] = used;
  endfunction

  // expected outcome of one request, updating the shadow bitmap
  function automatic outcome_t predict_request(pba_pkg::mode_t mode, int pg, int cnt);
    outcome_t res;
    int       words;
    int       run;
    int       first;
    bit       done;
    res.st = pba_pkg::ST_DONE;
    res.sp = '0;
    words  = words_used();
    run    = 0;
    first  = 0;
    done   = 1'b0;
    case (mode)
      pba_pkg::MODE_ALLOC: begin
        if (cnt == 0) begin
          res.st = pba_pkg::ST_IGNORED;
        end else begin
          res.st = pba_pkg::ST_NOFIT;
          for (int i = 0; i < words && !done; i++) begin
            if (used_map[i] == 32'hFFFF_FFFF) begin
              run = 0;
            end else begin
              for (int b = 0; b < 32 && !done; b++) begin
                if (!used_map[i][b]) begin
                  if (run == 0) first = i * 32 + b;
                  run++;
                  if (run == cnt) begin
                    for (int j = 0; j < cnt; j++) put_bit(first + j, 1'b1);
                    res.st = pba_pkg::ST_DONE;
                    res.sp = first[11:0];
                    done   = 1'b1;
                  end
                end else begin
                  run = 0;
                end
              end
            end
          end
        end
      end
      pba_pkg::MODE_FREE: begin
        if (pg == 0) begin
          res.st = pba_pkg::ST_IGNORED;
        end else begin
          for (int k = 0; k < cnt; k++) begin
            if ((pg + k) / 32 >= words) break;
            put_bit(pg + k, 1'b0);
          end
        end
      end
      default: begin
        if (pg >= managed_pages || pg >= pba_pkg::NUM_PAGES) res.st = pba_pkg::ST_IGNORED;
        else put_bit(pg, mode == pba_pkg::MODE_MARK_USED);
      end
    endcase
    return res;
  endfunction

  // write page_count once everything is back and the block is idle
  task automatic write_page_count(int value);
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[12:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    managed_pages = value & 13'h1FFF;
  endtask

  // offer one request and wait until it is taken
  task automatic send_request(pba_pkg::mode_t mode, int pg, int cnt, bit typed,
                              outcome_t typed_res);
    outcome_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= {mode, pg[11:0], cnt[12:0]};
    do @(posedge clk); while (!in_ch.ready);
    res = predict_request(mode, pg, cnt);
    pending_q.push_back(typed ? typed_res : res);
  endtask

  // result side: random backpressure, long hold when asked, and checking
  initial begin
    outcome_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t: result with no request pending: %h", $time, out_ch.data);
        end else begin
          want = pending_q.pop_front();
          if (out_ch.data[13:12] !== want.st) begin
            errors++;
            $display("%0t: status expected %0d got %0d", $time, want.st, out_ch.data[13:12]);
          end
          if (out_ch.data[11:0] !== want.sp) begin
            errors++;
            $display("%0t: start_page expected %0d got %0d", $time, want.sp,
                     out_ch.data[11:0]);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic row_t mk(bit is_cfg, pba_pkg::mode_t mode, int pg, int cnt, bit typed,
                              pba_pkg::status_t st, int sp);
    row_t r;
    r.is_cfg = is_cfg; r.mode = mode; r.page = pg; r.count = cnt;
    r.typed = typed; r.st = st; r.sp = sp;
    return r;
  endfunction

  // stimulus
  initial begin
    outcome_t       tres;
    pba_pkg::mode_t mode;
    int             pg;
    int             cnt;
    int             pick;
    phase_pages   = '{8191, 4096, 1000, 100, 64, 33, 0};
    errors        = 0;
    hold_cycles   = 0;
    send_idle_pct = 30;
    recv_idle_pct = 49;
    managed_pages = 0;
    foreach (used_map[i]) used_map[i] = 32'hFFFF_FFFF;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: reset state, extremes, rejections, saturation
    rows.push_back(mk(0, pba_pkg::MODE_ALLOC, 0, 1, 1, pba_pkg::ST_NOFIT, 0));
    rows.push_back(mk(0, pba_pkg::MODE_MARK_FREE, 0, 0, 1, pba_pkg::ST_IGNORED, 0));
    rows.push_back(mk(0, pba_pkg::MODE_FREE, 0, 5, 1, pba_pkg::ST_IGNORED, 0));
    rows.push_back(mk(1, pba_pkg::MODE_ALLOC, 0, 4096, 0, pba_pkg::ST_DONE, 0));
    rows.push_back(mk(0, pba_pkg::MODE_FREE, 1, 8191, 1, pba_pkg::ST_DONE, 0));
    rows.push_back(mk(0, pba_pkg::MODE_ALLOC, 0, 0, 1, pba_pkg::ST_IGNORED, 0));
    rows.push_back(mk(0, pba_pkg::MODE_ALLOC, 4095, 4095, 1, pba_pkg::ST_DONE, 1));
    rows.push_back(mk(0, pba_pkg::MODE_ALLOC, 0, 1, 1, pba_pkg::ST_NOFIT, 0));
    rows.push_back(mk(0, pba_pkg::MODE_MARK_FREE, 0, 0, 1, pba_pkg::ST_DONE, 0));
    rows.push_back(mk(0, pba_pkg::MODE_ALLOC, 0, 2, 1, pba_pkg::ST_NOFIT, 0));
    rows.push_back(mk(0, pba_pkg::MODE_ALLOC, 0, 1, 1, pba_pkg::ST_DONE, 0));
    rows.push_back(mk(0, pba_pkg::MODE_FREE, 4095, 1, 1, pba_pkg::ST_DONE, 0));
    rows.push_back(mk(0, pba_pkg::MODE_MARK_USED, 4095, 0, 1, pba_pkg::ST_DONE, 0));
    rows.push_back(mk(0, pba_pkg::MODE_MARK_FREE, 4095, 8191, 1, pba_pkg::ST_DONE, 0));
    rows.push_back(mk(0, pba_pkg::MODE_ALLOC, 0, 4096, 1, pba_pkg::ST_NOFIT, 0));
    rows.push_back(mk(0, pba_pkg::MODE_FREE, 40, 100, 0, pba_pkg::ST_DONE, 0));
    rows.push_back(mk(0, pba_pkg::MODE_ALLOC, 0, 33, 0, pba_pkg::ST_DONE, 0));
    rows.push_back(mk(0, pba_pkg::MODE_FREE, 4000, 200, 0, pba_pkg::ST_DONE, 0));
    rows.push_back(mk(1, pba_pkg::MODE_ALLOC, 0, 8191, 0, pba_pkg::ST_DONE, 0));
    rows.push_back(mk(0, pba_pkg::MODE_MARK_USED, 4095, 0, 1, pba_pkg::ST_DONE, 0));
    rows.push_back(mk(0, pba_pkg::MODE_ALLOC, 0, 50, 0, pba_pkg::ST_DONE, 0));
    rows.push_back(mk(1, pba_pkg::MODE_ALLOC, 0, 31, 0, pba_pkg::ST_DONE, 0));
    rows.push_back(mk(0, pba_pkg::MODE_ALLOC, 0, 1, 1, pba_pkg::ST_NOFIT, 0));
    rows.push_back(mk(0, pba_pkg::MODE_MARK_USED, 30, 0, 1, pba_pkg::ST_DONE, 0));
    rows.push_back(mk(0, pba_pkg::MODE_MARK_USED, 31, 0, 1, pba_pkg::ST_IGNORED, 0));
    rows.push_back(mk(0, pba_pkg::MODE_FREE, 1, 31, 1, pba_pkg::ST_DONE, 0));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_page_count(rows[i].count);
      end else begin
        tres.st = rows[i].st;
        tres.sp = rows[i].sp[11:0];
        send_request(rows[i].mode, rows[i].page, rows[i].count, rows[i].typed, tres);
      end
    end

    // random traffic over several page_count settings
    tres.st = pba_pkg::ST_DONE;
    tres.sp = '0;
    for (int n = 0; n < 1190; n++) begin
      if (n % 170 == 0) write_page_count(phase_pages[n / 170]);
      if (n == 400) begin
        send_idle_pct = 49;
        recv_idle_pct = 30;
      end else if (n == 800) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n == 100 || n == 900) hold_cycles = 400;
      pick = $urandom_range(99);
      pg   = (managed_pages > 1) ? $urandom_range((managed_pages > 4096 ? 4096 :
                                                   managed_pages) - 1, 1) : 0;
      if ($urandom_range(19) == 0) pg = $urandom_range(4095);
      cnt = ($urandom_range(19) == 0) ? $urandom_range(8191) : $urandom_range(48, 1);
      if (pick < 40) mode = pba_pkg::MODE_ALLOC;
      else if (pick < 75) mode = pba_pkg::MODE_FREE;
      else if (pick < 88) mode = pba_pkg::MODE_MARK_USED;
      else mode = pba_pkg::MODE_MARK_FREE;
      send_request(mode, pg, cnt, 1'b0, tres);
    end
    in_ch.valid <= 1'b0;

    // drain
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_q.size() != 0) errors++;
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
